// ===== src/ccs_pkg.sv =====
// Shared types and constants for the C comment stripper.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

  // Byte values that the scanner reacts to.
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNl     = 8'h0A;

  // Depth of the command queue between scanner and emitter.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One emit command: the byte to pass on, and whether a held slash goes out first.
  typedef struct packed {
    logic       dbl;
    logic [7:0] data;
  } ccs_cmd_t;

  // Queue status seen by the scanner and the emitter.
  typedef struct packed {
    logic full;
    logic empty;
  } ccs_qstat_t;

endpackage

`default_nettype wire

// ===== src/c_comment_stripper.sv =====
// Top level of the C comment stripper: scanner, command queue and emitter.
// Depends on ccs_pkg, ccs_front, ccs_queue and ccs_back.
//
// The block takes one byte of C source per input item and streams out the
// same text with line and block comments removed; string and character
// literals pass untouched, a line comment keeps its newline, and a slash not
// opening a comment leaves together with the next byte as two items, the
// second marked by tlast (a slash still held when input stops never leaves).
// The scanner accepts one byte every cycle while its four-entry command queue
// has room; the emitter's output register moves one item per cycle while the
// output is ready, a byte leaving as one item, or as two with a held slash.
// Input and output stall independently through the queue.
`timescale 1ns / 1ps
`default_nettype none

module c_comment_stripper import ccs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o    // last_of_run
);

  ccs_qstat_t qstat;
  ccs_cmd_t   push_cmd;
  ccs_cmd_t   head;
  logic       push;
  logic       pop;

  // Scanner: classifies bytes and issues emit commands.
  ccs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Queue decoupling the two halves.
  ccs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .qstat_o    (qstat)
  );

  // Emitter: drives the output stream.
  ccs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== src/ccs_front.sv =====
// Scanner front end of the C comment stripper: tracks the lexical state and
// turns each accepted byte into at most one emit command. Uses ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccs_front import ccs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire ccs_qstat_t qstat_i,
  output logic            push_o,
  output ccs_cmd_t        push_cmd_o
);

  // Scanner state codes.
  localparam logic [3:0] StNormal = 4'd0;
  localparam logic [3:0] StStr    = 4'd1;
  localparam logic [3:0] StChr    = 4'd2;
  localparam logic [3:0] StStrEsc = 4'd3;
  localparam logic [3:0] StChrEsc = 4'd4;
  localparam logic [3:0] StSlash  = 4'd5;
  localparam logic [3:0] StLine   = 4'd6;
  localparam logic [3:0] StBlock  = 4'd7;
  localparam logic [3:0] StStar   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       accept;
  logic       emit;
  logic       dbl;

  // Next state for a byte seen in normal text.
  function automatic logic [3:0] normal_next(input logic [7:0] b);
    logic [3:0] s;
    if (b == ChDquote) begin
      s = StStr;
    end else if (b == ChSquote) begin
      s = StChr;
    end else if (b == ChSlash) begin
      s = StSlash;
    end else begin
      s = StNormal;
    end
    return s;
  endfunction

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the incoming byte against the current state.
  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    dbl     = 1'b0;
    unique case (state_q)
      StStr: begin
        if (in_byte_i == ChBslash) begin
          state_d = StStrEsc;
        end else if (in_byte_i == ChDquote) begin
          state_d = StNormal;
        end
        emit = 1'b1;
      end
      StStrEsc: begin
        state_d = StStr;
        emit    = 1'b1;
      end
      StChr: begin
        if (in_byte_i == ChBslash) begin
          state_d = StChrEsc;
        end else if (in_byte_i == ChSquote) begin
          state_d = StNormal;
        end
        emit = 1'b1;
      end
      StChrEsc: begin
        state_d = StChr;
        emit    = 1'b1;
      end
      StSlash: begin
        if (in_byte_i == ChSlash) begin
          state_d = StLine;
        end else if (in_byte_i == ChStar) begin
          state_d = StBlock;
        end else begin
          // A lone slash goes out ahead of this byte, which is then normal text.
          state_d = normal_next(in_byte_i);
          emit    = 1'b1;
          dbl     = 1'b1;
        end
      end
      StLine: begin
        if (in_byte_i == ChNl) begin
          state_d = StNormal;
          emit    = 1'b1;
        end
      end
      StBlock: begin
        if (in_byte_i == ChStar) begin
          state_d = StStar;
        end
      end
      StStar: begin
        if (in_byte_i == ChSlash) begin
          state_d = StNormal;
        end else if (in_byte_i != ChStar) begin
          state_d = StBlock;
        end
      end
      default: begin
        // Normal text, and any unused code behaves the same.
        state_d = normal_next(in_byte_i);
        emit    = (in_byte_i != ChSlash);
      end
    endcase
  end

  assign push_o          = accept && emit;
  assign push_cmd_o.dbl  = dbl;
  assign push_cmd_o.data = in_byte_i;

  // The state advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StNormal;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ccs_queue.sv =====
// Small command queue between scanner and emitter of the C comment stripper.
// Uses ccs_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module ccs_queue import ccs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire ccs_cmd_t push_cmd_i,
  input  wire logic     pop_i,
  output ccs_cmd_t      head_o,
  output ccs_qstat_t    qstat_o
);

  ccs_cmd_t               mem_q [QDepth];
  logic     [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic     [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic     [QCntW-1:0]   count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign qstat_o.full  = (count_q == QCntW'(QDepth));
  assign qstat_o.empty = (count_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count exceeds depth");

  // The scanner never offers a command while the queue is full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("push into full queue");

  // The emitter pops only entries that are there.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== src/ccs_back.sv =====
// Emitter back end of the C comment stripper: expands queued commands into
// one or two output items through an output register. Uses ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccs_back import ccs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ccs_cmd_t   head_i,
  input  wire ccs_qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       phase_q, phase_d;
  logic       take;
  logic       head_valid;

  assign head_valid = !qstat_i.empty;
  assign take       = !out_valid_q || out_ready_i;

  // Load the output register from the queue head whenever it is free or its item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    if (take) begin
      out_valid_d = head_valid;
      if (head_valid) begin
        if (head_i.dbl && !phase_q) begin
          // The held slash goes out first; the entry stays for its byte.
          out_byte_d = ChSlash;
          out_last_d = 1'b0;
          phase_d    = 1'b1;
        end else begin
          out_byte_d = head_i.data;
          out_last_d = 1'b1;
          phase_d    = 1'b0;
          pop_o      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // While the second half of a pair is owed, its entry is still at the head.
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_valid && head_i.dbl))
    else $error("pending pair lost its queue entry");

  // An item that is not last of its run is always the held slash.
  a_first_is_slash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_byte_q == ChSlash))
    else $error("non-final item is not a slash");

endmodule

`default_nettype wire
